[hw/rtl/rtcnt_pkg.sv]
// ============================================================================
// rtcnt_pkg: shared types and constants for the range toggle count tree
// Sizes of the row and the node store, and the walk sequencer states.
// ============================================================================
package rtcnt_pkg;

   localparam int unsigned MaxLength = 1024;
   localparam int unsigned IdxW      = $clog2(MaxLength);
   localparam int unsigned LenW      = IdxW + 1;
   localparam int unsigned NodeCount = 4 * MaxLength;
   localparam int unsigned NodeW     = $clog2(NodeCount);
   localparam int unsigned DepthMax  = IdxW + 2;
   localparam int unsigned SpW       = $clog2(DepthMax);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_VISIT,
      ST_RET,
      ST_DONE
   } walk_state_type;

   typedef struct packed {
      logic [NodeW-1:0] node;
      logic [IdxW-1:0]  lo;
      logic [IdxW-1:0]  hi;
      logic             flip;
      logic             kflip;
      logic             phase;
      logic [LenW-1:0]  lsum;
   } frame_type;

endpackage

[hw/rtl/rtcnt_node_ram.sv]
// ============================================================================
// rtcnt_node_ram: node store of the tree
// One write port and one registered read port; each word holds a node's
// ones count and its pending invert mark.
// ============================================================================
module rtcnt_node_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [rtcnt_pkg::NodeW-1:0] wr_addr,
   input  logic [rtcnt_pkg::LenW:0]  wr_data,
   input  logic [rtcnt_pkg::NodeW-1:0] rd_addr,
   output logic [rtcnt_pkg::LenW:0]  rd_data
);
   import rtcnt_pkg::*;

   logic [LenW:0] mem [NodeCount];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/range_toggle_count_tree.sv]
// ============================================================================
// range_toggle_count_tree: bit row with range toggle and range count
// Segment tree with lazy invert marks, walked by a sequencer over a node
// memory with an explicit stack.
// ============================================================================
//   channel | direction | carries
//   req     | in        | operation, range_start, range_end
//   rsp     | out       | ones_count, one beat per count operation
//   csr     | in        | active_length, clears the row
//
// Each visited node passes through the read, update and return states, and a
// walk ends in the done state, which issues the rsp beat of a count.
// After reset and after each csr write the node memory is swept clear, one
// node a cycle over all 4096 nodes, during which req_ready and csr_ready are
// low.
// A count holds in its last state while the previous rsp beat is pending.
module range_toggle_count_tree (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [rtcnt_pkg::IdxW-1:0] req_range_start,
   input  logic [rtcnt_pkg::IdxW-1:0] req_range_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rtcnt_pkg::LenW-1:0] rsp_ones_count,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rtcnt_pkg::LenW-1:0] csr_active_length
);
   import rtcnt_pkg::*;

   walk_state_type   state_ff, state_in;
   logic [NodeW-1:0] clr_ff, clr_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic             op_ff, op_in;
   logic [IdxW-1:0]  first_ff, first_in, last_ff, last_in;
   frame_type        stack_ff [DepthMax];
   logic [SpW-1:0]   top_ff;
   logic [LenW-1:0]  ret_ff, ret_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LenW-1:0]  rsp_ff, rsp_in;

   logic             wr_en;
   logic [NodeW-1:0] wr_addr, rd_addr;
   logic [LenW:0]    wr_data, rd_data;

   frame_type        cur, par, root_frame, left_frame, right_frame, par_done, cur_marked;
   logic [IdxW-1:0]  cur_mid, par_mid, top_idx, clip_last;
   logic [LenW-1:0]  span, ones_now, ones_flipped, pair_sum;
   logic             mark_now, outside, covered, req_empty;
   logic             cfg_take, req_take, start_walk, descend, to_right, combine;

   rtcnt_node_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign cur       = stack_ff[top_ff];
   assign par       = (top_ff == '0) ? cur : stack_ff[top_ff - SpW'(1)];
   assign cur_mid   = cur.lo + ((cur.hi - cur.lo) >> 1);
   assign par_mid   = par.lo + ((par.hi - par.lo) >> 1);
   assign span      = LenW'(cur.hi) - LenW'(cur.lo) + LenW'(1);
   assign mark_now  = rd_data[LenW] ^ cur.flip;
   assign ones_now  = cur.flip ? span - rd_data[LenW-1:0] : rd_data[LenW-1:0];
   assign ones_flipped = cur.flip ? rd_data[LenW-1:0] : span - rd_data[LenW-1:0];
   assign outside   = (cur.lo > last_ff) || (cur.hi < first_ff);
   assign covered   = (cur.lo >= first_ff) && (cur.hi <= last_ff);
   assign pair_sum  = par.lsum + ret_ff;
   assign top_idx   = IdxW'(len_ff - LenW'(1));
   assign clip_last = (req_range_end > top_idx) ? top_idx : req_range_end;
   assign req_empty = (req_range_start > clip_last);

   assign cfg_take   = csr_valid && csr_ready;
   assign req_take   = req_valid && req_ready;
   assign start_walk = req_take && !req_empty;
   assign descend    = (state_ff == ST_VISIT) && !outside && !covered;
   assign to_right   = (state_ff == ST_RET) && (top_ff != '0) && !par.phase;
   assign combine    = (state_ff == ST_RET) && (top_ff != '0) && par.phase;

   assign root_frame = '{node: NodeW'(1), lo: '0, hi: top_idx, flip: 1'b0,
                         kflip: 1'b0, phase: 1'b0, lsum: '0};
   assign left_frame = '{node: {cur.node[NodeW-2:0], 1'b0}, lo: cur.lo, hi: cur_mid,
                         flip: mark_now, kflip: 1'b0, phase: 1'b0, lsum: '0};
   assign right_frame = '{node: {par.node[NodeW-2:0], 1'b1}, lo: par_mid + IdxW'(1),
                          hi: par.hi, flip: par.kflip, kflip: 1'b0, phase: 1'b0,
                          lsum: '0};
   assign par_done   = '{node: par.node, lo: par.lo, hi: par.hi, flip: par.flip,
                         kflip: par.kflip, phase: 1'b1, lsum: ret_ff};
   assign cur_marked = '{node: cur.node, lo: cur.lo, hi: cur.hi, flip: cur.flip,
                         kflip: mark_now, phase: cur.phase, lsum: cur.lsum};

   assign req_ready = (state_ff == ST_IDLE) && !cfg_take;
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ones_count = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (clr_ff == NodeW'(NodeCount - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (cfg_take) begin
               state_in = ST_CLEAR;
            end else if (req_take) begin
               state_in = req_empty ? ST_DONE : ST_READ;
            end
         end
         ST_READ:     state_in = ST_VISIT;
         ST_VISIT:    state_in = descend ? ST_READ : ST_RET;
         ST_RET: begin
            if (top_ff == '0) state_in = ST_DONE;
            else if (!par.phase) state_in = ST_READ;
         end
         ST_DONE:     if (!(op_ff && rsp_valid_ff)) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in = clr_ff; len_in = len_ff; op_in = op_ff;
      first_in = first_ff; last_in = last_ff;
      ret_in = ret_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = cur.node; wr_data = '0; rd_addr = cur.node;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff;
            clr_in = clr_ff + NodeW'(1);
         end
         ST_IDLE: begin
            clr_in = '0; ret_in = '0;
            if (cfg_take) begin
               if (csr_active_length == '0) len_in = LenW'(1);
               else if (csr_active_length > LenW'(MaxLength)) len_in = LenW'(MaxLength);
               else len_in = csr_active_length;
            end else if (req_take) begin
               op_in = req_operation; first_in = req_range_start; last_in = clip_last;
            end
         end
         ST_VISIT: begin
            wr_en = 1'b1;
            if (descend) begin
               wr_data = {1'b0, ones_now};
            end else if (covered && !op_ff) begin
               wr_data = {!mark_now, ones_flipped};
               ret_in = ones_flipped;
            end else begin
               wr_data = {mark_now, ones_now};
               ret_in = (op_ff && outside) ? '0 : ones_now;
            end
         end
         ST_RET: begin
            if (combine) begin
               ret_in = pair_sum;
               wr_en = !op_ff;
               wr_addr = par.node;
               wr_data = {1'b0, pair_sum};
            end
         end
         ST_DONE: begin
            if (op_ff && !rsp_valid_ff) begin
               rsp_valid_in = 1'b1; rsp_in = ret_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         len_ff <= LenW'(MaxLength);
         top_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         len_ff <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (start_walk) begin
            stack_ff[0] <= root_frame;
            top_ff <= '0;
         end else if (descend) begin
            stack_ff[top_ff] <= cur_marked;
            stack_ff[top_ff + SpW'(1)] <= left_frame;
            top_ff <= top_ff + SpW'(1);
         end else if (to_right) begin
            stack_ff[top_ff - SpW'(1)] <= par_done;
            stack_ff[top_ff] <= right_frame;
         end else if (combine) begin
            top_ff <= top_ff - SpW'(1);
         end
      end
      op_ff <= op_in; first_ff <= first_in; last_ff <= last_in;
      ret_ff <= ret_in; rsp_ff <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ones_count))
      else $error("rsp beat dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      top_ff < SpW'(DepthMax))
      else $error("walk stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready && !csr_ready)
      else $error("handshake open during the clear sweep");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ones_count <= LenW'(MaxLength))
      else $error("count beyond the row size");

endmodule
